[design/tbcd_pkg.sv]
// shared constants, register codes and transaction types of the burst coincidence detector
package tbcd_pkg;

   localparam int MAX_HITS     = 16;
   localparam int HIST_IDX_W   = $clog2(MAX_HITS);
   localparam int REQ_USED_W   = $clog2(MAX_HITS + 1);

   localparam int TIME_W       = 48;
   localparam int CHUNK_W      = 16;
   localparam int BITS_W       = 16;
   localparam int CNT_W        = 32;
   localparam int REQ_W        = 5;

   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_MASK  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_TICKS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HITS_REQUIRED = 2'd2;

   localparam logic [BITS_W-1:0] RESET_TRIGGER_MASK  = 16'd2;
   localparam logic [TIME_W-1:0] RESET_WINDOW_TICKS  = 48'd50000000;
   localparam logic [REQ_W-1:0]  RESET_HITS_REQUIRED = 5'd2;

   localparam logic [CNT_W-1:0]  CNT_MAX = {CNT_W{1'b1}};

   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic              matched;
      logic [TIME_W-1:0] stamp;
   } hit_item_type;

   typedef struct packed {
      logic             matched;
      logic             candidate;
      logic [CNT_W-1:0] hit_count;
      logic [CNT_W-1:0] candidate_count;
   } result_type;

   typedef struct packed {
      logic [TIME_W-1:0] window_ticks;
      logic [REQ_W-1:0]  hits_required;
   } back_cfg_type;

   typedef struct packed {
      logic empty;
      logic pop;
   } queue_ctrl_type;

endpackage

[design/tbcd_front.sv]
// front end: takes trigger records, checks the mask and packs the timestamp
module tbcd_front (
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [tbcd_pkg::BITS_W-1:0]     req_trigger_bits,
   input  logic [tbcd_pkg::CHUNK_W-1:0]    req_time_high,
   input  logic [tbcd_pkg::CHUNK_W-1:0]    req_time_mid,
   input  logic [tbcd_pkg::CHUNK_W-1:0]    req_time_low,
   input  logic [tbcd_pkg::BITS_W-1:0]     trigger_mask,
   input  logic                            queue_full,
   output logic                            queue_push,
   output tbcd_pkg::hit_item_type          queue_item
);
   import tbcd_pkg::*;

   assign req_full   = queue_full;
   assign queue_push = req_push && !queue_full;

   // a zero mask lets every record through
   assign queue_item.matched = ((req_trigger_bits & trigger_mask) == trigger_mask);
   assign queue_item.stamp   = {req_time_high, req_time_mid, req_time_low};

endmodule

[design/tbcd_queue.sv]
// short queue of classified records between the front end and the back end
module tbcd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  tbcd_pkg::hit_item_type     push_item,
   output logic                       full,
   input  logic                       pop,
   output tbcd_pkg::queue_ctrl_type   status,
   output tbcd_pkg::hit_item_type     head_item
);
   import tbcd_pkg::*;

   hit_item_type           mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full         = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign status.pop   = do_pop;
   assign do_push      = push && !full;
   assign do_pop       = pop && !status.empty;
   assign head_item    = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[design/tbcd_back.sv]
// back end: hit history, window test, saturating counters and result buffer
module tbcd_back (
   input  logic                            clock,
   input  logic                            reset,
   input  tbcd_pkg::back_cfg_type          cfg,
   input  tbcd_pkg::queue_ctrl_type        queue_status,
   input  tbcd_pkg::hit_item_type          item,
   output logic                            queue_pop,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output tbcd_pkg::result_type            rsp_item
);
   import tbcd_pkg::*;

   logic [TIME_W-1:0]      hist_ff [MAX_HITS];
   logic [TIME_W-1:0]      hist_in [MAX_HITS];
   logic [CNT_W-1:0]       hits_ff, hits_in;
   logic [CNT_W-1:0]       bursts_ff, bursts_in;
   logic [CNT_W-1:0]       hits_inc;
   logic [CNT_W-1:0]       bursts_inc;
   logic [REQ_USED_W-1:0]  req_used;
   logic [HIST_IDX_W-1:0]  oldest_sel;
   logic [TIME_W-1:0]      oldest;
   logic [TIME_W:0]        span;
   logic                   in_window;
   logic                   candidate;
   logic                   take;
   result_type             result;

   result_type             out_mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] out_wr_ff, out_wr_in;
   logic [QUEUE_PTR_W-1:0] out_rd_ff, out_rd_in;
   logic [QUEUE_CNT_W-1:0] out_cnt_ff, out_cnt_in;
   logic                   out_pop;

   assign take      = !queue_status.empty && (out_cnt_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign queue_pop = take;

   always_comb begin
      if (cfg.hits_required < REQ_W'(2)) begin
         req_used = REQ_USED_W'(2);
      end else if (32'(cfg.hits_required) > MAX_HITS) begin
         req_used = REQ_USED_W'(MAX_HITS);
      end else begin
         req_used = REQ_USED_W'(cfg.hits_required);
      end
   end

   // after the shift the oldest compared hit sits one place further back
   assign oldest_sel = HIST_IDX_W'(req_used - REQ_USED_W'(2));
   assign oldest     = hist_ff[oldest_sel];
   assign span       = {1'b0, item.stamp} - {1'b0, oldest};
   // time running backwards counts as inside the window
   assign in_window  = span[TIME_W] || (span[TIME_W-1:0] <= cfg.window_ticks);

   assign hits_inc   = (hits_ff == CNT_MAX) ? hits_ff : hits_ff + 1'b1;
   assign bursts_inc = (bursts_ff == CNT_MAX) ? bursts_ff : bursts_ff + 1'b1;
   assign candidate  = item.matched && (hits_inc >= CNT_W'(req_used)) && in_window;

   always_comb begin
      hits_in   = hits_ff;
      bursts_in = bursts_ff;
      hist_in   = hist_ff;
      if (take && item.matched) begin
         hits_in    = hits_inc;
         hist_in[0] = item.stamp;
         for (int i = 1; i < MAX_HITS; i++) begin
            hist_in[i] = hist_ff[i-1];
         end
         if (candidate) begin
            bursts_in = bursts_inc;
         end
      end
   end

   always_comb begin
      result.matched         = item.matched;
      result.candidate       = candidate;
      result.hit_count       = hits_in;
      result.candidate_count = bursts_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff   <= '0;
         bursts_ff <= '0;
      end else begin
         hits_ff   <= hits_in;
         bursts_ff <= bursts_in;
      end
   end

   // history has no reset: entries are only read once that many hits are in
   always_ff @(posedge clock) begin
      hist_ff <= hist_in;
   end

   // result buffer
   assign rsp_empty = (out_cnt_ff == '0);
   assign out_pop   = rsp_pop && !rsp_empty;
   assign rsp_item  = out_mem[out_rd_ff];

   always_comb begin
      out_wr_in = out_wr_ff;
      out_rd_in = out_rd_ff;
      if (take) begin
         out_wr_in = (out_wr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : out_wr_ff + 1'b1;
      end
      if (out_pop) begin
         out_rd_in = (out_rd_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : out_rd_ff + 1'b1;
      end
      unique case ({take, out_pop})
         2'b10:   out_cnt_in = out_cnt_ff + 1'b1;
         2'b01:   out_cnt_in = out_cnt_ff - 1'b1;
         default: out_cnt_in = out_cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff  <= '0;
         out_rd_ff  <= '0;
         out_cnt_ff <= '0;
      end else begin
         out_wr_ff  <= out_wr_in;
         out_rd_ff  <= out_rd_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_mem[out_wr_ff] <= result;
      end
   end

   a_bursts_within_hits: assert property (@(posedge clock) disable iff (reset)
      bursts_ff <= hits_ff)
      else $error("candidate count ran ahead of hit count");

   a_hits_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> hits_ff >= $past(hits_ff))
      else $error("hit count went backwards");

   a_candidate_on_hit: assert property (@(posedge clock) disable iff (reset)
      take && !item.matched |=> hits_ff == $past(hits_ff) && bursts_ff == $past(bursts_ff))
      else $error("counters moved on a non-matching transaction");

   a_buffer_bound: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("result buffer overfilled");

   a_queue_pop_seen: assert property (@(posedge clock) disable iff (reset)
      queue_status.pop == take)
      else $error("queue pop does not follow the back end take");

endmodule

[design/trigger_burst_coincidence_detector_unit.sv]
// burst coincidence detector: one result per record; with empty queues a record accepted
// goes into the input queue, then its result into the result buffer, shown on the rsp ports to pop.
// one record per cycle sustained while the result buffer is not full, set by the history shift plus
// 48-bit window subtract and compare in the back end; a full result buffer stalls takes until a pop.
// reset (synchronous): registers to their defaults, counters and queues cleared;
// the hit history is not cleared and needs no clearing pass.
module trigger_burst_coincidence_detector_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [tbcd_pkg::BITS_W-1:0]     req_trigger_bits,
   input  logic [tbcd_pkg::CHUNK_W-1:0]    req_time_high,
   input  logic [tbcd_pkg::CHUNK_W-1:0]    req_time_mid,
   input  logic [tbcd_pkg::CHUNK_W-1:0]    req_time_low,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic                            rsp_matched,
   output logic                            rsp_candidate,
   output logic [tbcd_pkg::CNT_W-1:0]      rsp_hit_count,
   output logic [tbcd_pkg::CNT_W-1:0]      rsp_candidate_count,
   input  logic                            csr_write,
   input  logic [tbcd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tbcd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tbcd_pkg::*;

   logic [BITS_W-1:0] trigger_mask_ff, trigger_mask_in;
   logic [TIME_W-1:0] window_ticks_ff, window_ticks_in;
   logic [REQ_W-1:0]  hits_required_ff, hits_required_in;

   logic              queue_full;
   logic              queue_push;
   hit_item_type      queue_item;
   hit_item_type      head_item;
   queue_ctrl_type    queue_status;
   logic              queue_pop;
   back_cfg_type      back_cfg;
   result_type        rsp_item;

   always_comb begin
      trigger_mask_in  = trigger_mask_ff;
      window_ticks_in  = window_ticks_ff;
      hits_required_in = hits_required_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_TRIGGER_MASK:  trigger_mask_in  = csr_wdata[BITS_W-1:0];
            CSR_WINDOW_TICKS:  window_ticks_in  = csr_wdata[TIME_W-1:0];
            CSR_HITS_REQUIRED: hits_required_in = csr_wdata[REQ_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_mask_ff  <= RESET_TRIGGER_MASK;
         window_ticks_ff  <= RESET_WINDOW_TICKS;
         hits_required_ff <= RESET_HITS_REQUIRED;
      end else begin
         trigger_mask_ff  <= trigger_mask_in;
         window_ticks_ff  <= window_ticks_in;
         hits_required_ff <= hits_required_in;
      end
   end

   assign back_cfg.window_ticks  = window_ticks_ff;
   assign back_cfg.hits_required = hits_required_ff;

   tbcd_front u_front (
      .req_push         (req_push),
      .req_full         (req_full),
      .req_trigger_bits (req_trigger_bits),
      .req_time_high    (req_time_high),
      .req_time_mid     (req_time_mid),
      .req_time_low     (req_time_low),
      .trigger_mask     (trigger_mask_ff),
      .queue_full       (queue_full),
      .queue_push       (queue_push),
      .queue_item       (queue_item)
   );

   tbcd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_item (queue_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .status    (queue_status),
      .head_item (head_item)
   );

   tbcd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (back_cfg),
      .queue_status (queue_status),
      .item         (head_item),
      .queue_pop    (queue_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_item     (rsp_item)
   );

   assign rsp_matched         = rsp_item.matched;
   assign rsp_candidate       = rsp_item.candidate;
   assign rsp_hit_count       = rsp_item.hit_count;
   assign rsp_candidate_count = rsp_item.candidate_count;

endmodule

[tb/tb_top.sv]
// testbench of the burst coincidence detector: directed and random records checked against a predictor
`timescale 1ns / 100ps

module tb_top;
   import tbcd_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic [BITS_W-1:0]     req_trigger_bits = '0;
   logic [CHUNK_W-1:0]    req_time_high = '0;
   logic [CHUNK_W-1:0]    req_time_mid = '0;
   logic [CHUNK_W-1:0]    req_time_low = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic                  rsp_matched;
   logic                  rsp_candidate;
   logic [CNT_W-1:0]      rsp_hit_count;
   logic [CNT_W-1:0]      rsp_candidate_count;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_TRIGGER_MASK;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state and register mirror
   logic [TIME_W-1:0] hit_hist [MAX_HITS];
   logic [CNT_W-1:0]  hits_total = '0;
   logic [CNT_W-1:0]  bursts_total = '0;
   logic [BITS_W-1:0] mask_cfg = RESET_TRIGGER_MASK;
   logic [TIME_W-1:0] window_cfg = RESET_WINDOW_TICKS;
   int                req_used = 2;

   result_type pending_results[$];

   int fail_count = 0;
   int results_checked = 0;
   int hits_observed = 0;
   int bursts_observed = 0;
   int settings_applied = 0;
   int idle_pct = 0;
   int stall_pct = 30;
   int pop_hold = 0;

   trigger_burst_coincidence_detector_unit i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_trigger_bits    (req_trigger_bits),
      .req_time_high       (req_time_high),
      .req_time_mid        (req_time_mid),
      .req_time_low        (req_time_low),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_matched         (rsp_matched),
      .rsp_candidate       (rsp_candidate),
      .rsp_hit_count       (rsp_hit_count),
      .rsp_candidate_count (rsp_candidate_count),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #2 clock = ~clock;

   initial begin
      #1_000_000;
      $display("FAIL");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_idle(input int pct);
      if ($urandom_range(0, 99) >= pct) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic result_type score_record(input logic [BITS_W-1:0] bits,
                                               input logic [TIME_W-1:0] stamp);
      result_type        r;
      logic [TIME_W-1:0] oldest;
      r = '0;
      r.matched = ((bits & mask_cfg) == mask_cfg);
      if (r.matched) begin
         if (hits_total != CNT_MAX) hits_total = hits_total + 1'b1;
         for (int i = MAX_HITS - 1; i > 0; i--) hit_hist[i] = hit_hist[i-1];
         hit_hist[0] = stamp;
         if (hits_total >= req_used) begin
            oldest = hit_hist[req_used-1];
            // a timestamp going backwards counts as inside the window
            r.candidate = (stamp < oldest) || (stamp - oldest <= window_cfg);
         end
         if (r.candidate && bursts_total != CNT_MAX) bursts_total = bursts_total + 1'b1;
      end
      r.hit_count = hits_total;
      r.candidate_count = bursts_total;
      return r;
   endfunction

   function automatic void report_field(input string name, input logic [CNT_W-1:0] want,
                                        input logic [CNT_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   task automatic push_record(input logic [BITS_W-1:0] bits, input logic [TIME_W-1:0] stamp,
                              input int gap);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push         <= 1'b1;
      req_trigger_bits <= bits;
      req_time_high    <= stamp[47:32];
      req_time_mid     <= stamp[31:16];
      req_time_low     <= stamp[15:0];
      @(posedge clock);
      while (req_full !== 1'b0) @(posedge clock);
      pending_results.push_back(score_record(bits, stamp));
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // writes all three registers back to back; only called while the block is idle
   task automatic apply_settings(input logic [BITS_W-1:0] mask, input logic [TIME_W-1:0] window,
                                 input logic [REQ_W-1:0] required);
      csr_write <= 1'b1;
      csr_index <= CSR_TRIGGER_MASK;
      csr_wdata <= CSR_DATA_W'(mask);
      @(posedge clock);
      csr_index <= CSR_WINDOW_TICKS;
      csr_wdata <= CSR_DATA_W'(window);
      @(posedge clock);
      csr_index <= CSR_HITS_REQUIRED;
      csr_wdata <= CSR_DATA_W'(required);
      @(posedge clock);
      csr_write <= 1'b0;
      mask_cfg   = mask;
      window_cfg = window;
      req_used   = int'(required);
      if (req_used < 2) req_used = 2;
      if (req_used > MAX_HITS) req_used = MAX_HITS;
      settings_applied++;
   endtask

   always @(posedge clock) begin : result_check
      result_type want;
      if (!reset && rsp_pop && rsp_empty === 1'b0) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual hit_count %0h",
                     $time, rsp_hit_count);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            report_field("matched", CNT_W'(want.matched), CNT_W'(rsp_matched));
            report_field("candidate", CNT_W'(want.candidate), CNT_W'(rsp_candidate));
            report_field("hit_count", want.hit_count, rsp_hit_count);
            report_field("candidate_count", want.candidate_count, rsp_candidate_count);
            results_checked++;
            if (want.matched) hits_observed++;
            if (want.candidate) bursts_observed++;
         end
      end
      if (pop_hold > 0) begin
         rsp_pop <= 1'b0;
         pop_hold--;
      end else begin
         rsp_pop <= 1'b1;
         pop_hold = pick_idle(stall_pct);
      end
   end

   // reset values: mask 2, window 50000000, two hits
   task automatic test_default_settings();
      push_record(16'h0000, 48'd100, 0);
      push_record(16'hFFFF, 48'd1000, 0);
      push_record(16'h0002, 48'd50_001_000, pick_idle(30));
      push_record(16'h0002, 48'd100_001_001, 0);
   endtask

   // zero mask lets everything through; zero window; required below two clamps up
   task automatic test_zero_mask_and_window();
      wait_drained();
      apply_settings(16'h0000, 48'd0, 5'd0);
      push_record(16'h0000, 48'd100_001_001, 0);
      push_record(16'h0000, 48'd5, pick_idle(30));
      push_record(16'h0000, 48'd6, 0);
   endtask

   // full mask, widest window, required above the history depth clamps down
   task automatic test_full_mask_and_deep_history();
      logic [TIME_W-1:0] stamp;
      wait_drained();
      apply_settings(16'hFFFF, {TIME_W{1'b1}}, 5'd31);
      push_record(16'hFFFE, {TIME_W{1'b1}}, 0);
      for (int i = 0; i < MAX_HITS; i++) begin
         stamp = (i % 2) ? {16'h0000, 16'hFFFF, 16'(i)} : {16'hFFFF, 16'h0000, ~16'(i)};
         push_record(16'hFFFF, stamp, pick_idle(20));
      end
   endtask

   // mostly bursts spaced near the window, with stalls, backward steps and random noise
   task automatic test_random_bursts();
      logic [BITS_W-1:0] mask;
      logic [TIME_W-1:0] window;
      logic [REQ_W-1:0]  required;
      logic [TIME_W-1:0] now;
      logic [BITS_W-1:0] bits;
      logic [63:0]       step;
      int                pick;
      now = TIME_W'({$urandom, $urandom});
      for (int ph = 0; ph < 8; ph++) begin
         wait_drained();
         case ($urandom_range(0, 5))
            0:       mask = 16'h0000;
            1:       mask = 16'hFFFF;
            default: mask = 16'($urandom & $urandom & $urandom);
         endcase
         case ($urandom_range(0, 5))
            0:       window = '0;
            1:       window = {TIME_W{1'b1}};
            2:       window = TIME_W'($urandom_range(1, 64));
            3:       window = TIME_W'({$urandom, $urandom});
            default: window = TIME_W'($urandom_range(100, 100_000));
         endcase
         required = (ph == 0) ? 5'd16 : (ph == 1) ? 5'd1 : 5'($urandom_range(0, 31));
         apply_settings(mask, window, required);
         idle_pct  = (ph == 2) ? 0 : $urandom_range(10, 50);
         stall_pct = (ph == 2) ? 0 : $urandom_range(10, 50);
         step = 64'(window_cfg) / 64'(req_used - 1) + 64'd1;
         for (int i = 0; i < 66; i++) begin
            if (i == 33 && ph % 3 == 1) wait_drained();
            bits = ($urandom_range(0, 9) < 7) ? (mask_cfg | 16'($urandom)) : 16'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 70)
               now = now + TIME_W'({$urandom, $urandom} % (step + step / 2 + 64'd2));
            else if (pick < 80)
               now = now;
            else if (pick < 90)
               now = now - TIME_W'($urandom_range(1, 1000));
            else
               now = TIME_W'({$urandom, $urandom});
            push_record(bits, now, pick_idle(idle_pct));
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_default_settings();
      test_zero_mask_and_window();
      test_full_mask_and_deep_history();
      test_random_bursts();
      wait_drained();
      repeat (10) @(posedge clock);
      $display("checked %0d records under %0d register settings after reset",
               results_checked, settings_applied);
      $display("records matching the mask: %0d, burst candidates: %0d",
               hits_observed, bursts_observed);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
